/* rtl/aamr_pkg.sv */
// Shared constants and types for the axis-angle matrix rotate unit.
`timescale 1ns / 1ps

package aamr_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_COUNT    = 24;
  localparam int CORDIC_RUN    = (CORDIC_STAGES < ATAN_COUNT) ? CORDIC_STAGES : ATAN_COUNT;

  // CORDIC datapath width: x, y and z stay well inside 34 signed bits.
  localparam int CW = 34;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 31;

  localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;
  localparam logic signed [CW-1:0] Q30_ONE   = 34'sd1073741824;

  localparam logic [31:0] ATAN_TURNS [ATAN_COUNT] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef logic [4:0] step_t;

endpackage

/* rtl/axis_angle_matrix_rotate_unit.sv */
// Top level: rotates one model matrix row by an axis-angle rotation per request.
`timescale 1ns / 1ps

// Fully pipelined: a request is taken on every cycle that start is high (busy is
// always low), and its result appears on done, one per accepted request and in
// order. The depth comes from the 32-step square root row, the 31-step divider
// rows that normalize the axis, the 16-step CORDIC row and the magnitude, shift,
// square, Rodrigues and row product stages. A zero axis returns the row
// unchanged with zero_axis set.
module axis_angle_matrix_rotate_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        turn_angle,
  input  logic signed [31:0] axis_x,
  input  logic signed [31:0] axis_y,
  input  logic signed [31:0] axis_z,
  input  logic signed [31:0] model_c0,
  input  logic signed [31:0] model_c1,
  input  logic signed [31:0] model_c2,
  input  logic signed [31:0] model_c3,
  output logic               done,
  output logic signed [31:0] out_c0,
  output logic signed [31:0] out_c1,
  output logic signed [31:0] out_c2,
  output logic signed [31:0] out_c3,
  output logic               zero_axis,
  output logic               saturated
);

  localparam int CW      = aamr_pkg::CW;
  localparam int ST_IN   = 0;
  localparam int ST_MAG  = 1;
  localparam int ST_SH   = 2;
  localparam int ST_NORM = 3;
  localparam int ST_SUM  = 5;
  localparam int ST_LEN  = ST_SUM + aamr_pkg::SQRT_STEPS;
  localparam int ST_Q    = ST_LEN + aamr_pkg::DIV_STEPS;
  localparam int ST_CS   = ST_Q + aamr_pkg::CORDIC_RUN;
  localparam int NST     = ST_CS + 6;

  typedef struct packed {
    logic             zero;
    logic [2:0]       neg;
    logic [15:0]      angle;
    logic [3:0][31:0] m;
    logic [2:0][31:0] g;
    logic [2:0][31:0] u;
  } side_t;

  function automatic logic signed [31:0] clamp_unit(input logic signed [CW:0] v);
    logic signed [CW:0] lim;
    lim = {{(CW - 30){1'b0}}, 1'b1, 30'd0};
    if (v > lim) begin
      clamp_unit = 32'sh4000_0000;
    end else if (v < -lim) begin
      clamp_unit = -32'sh4000_0000;
    end else begin
      clamp_unit = v[31:0];
    end
  endfunction

  side_t side     [NST+1];
  side_t side_fwd [NST+1];
  logic  vld      [NST+1];

  logic [4:0]  sh;
  logic [63:0] sq [3];
  logic [63:0] nsum;

  logic [63:0] sq_rem  [aamr_pkg::SQRT_STEPS+1];
  logic [63:0] sq_root [aamr_pkg::SQRT_STEPS+1];

  logic [31:0] dv_len [3][aamr_pkg::DIV_STEPS+1];
  logic [31:0] dv_rem [3][aamr_pkg::DIV_STEPS+1];
  logic [30:0] dv_q   [3][aamr_pkg::DIV_STEPS+1];

  logic signed [CW-1:0] cx [aamr_pkg::CORDIC_RUN+1];
  logic signed [CW-1:0] cy [aamr_pkg::CORDIC_RUN+1];
  logic signed [CW-1:0] cz [aamr_pkg::CORDIC_RUN+1];

  logic [31:0] phase;
  logic        flip_in;
  logic        flip_out;

  logic signed [CW-1:0] c1, s1, t1;
  logic signed [CW-1:0] c2, s2;
  logic signed [CW-1:0] tm [3];
  logic signed [CW-1:0] c3;
  logic signed [CW-1:0] pt [3][3];
  logic signed [CW-1:0] ps [3];
  logic signed [31:0]   r  [3][3];
  logic signed [63:0]   mr [3][3];

  logic [31:0] mx;
  logic [4:0]  msb;

  assign busy = 1'b0;

  // Input capture.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= start;
    end
    if (start) begin
      side[0].zero  <= 1'b0;
      side[0].neg   <= '0;
      side[0].angle <= turn_angle;
      side[0].m     <= {model_c3, model_c2, model_c1, model_c0};
      side[0].g     <= {axis_z, axis_y, axis_x};
      side[0].u     <= '0;
    end
  end

  genvar k;
  generate
    for (k = 1; k <= NST; k++) begin : g_stage
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else begin
          vld[k] <= vld[k-1];
        end
        side[k] <= side_fwd[k-1];
      end
    end

    for (k = 0; k <= NST; k++) begin : g_fwd
      if (k == ST_IN) begin : g_abs
        always_comb begin
          side_fwd[k] = side[k];
          side_fwd[k].zero = (side[k].g == '0);
          for (int a = 0; a < 3; a++) begin
            side_fwd[k].neg[a] = side[k].g[a][31];
            side_fwd[k].g[a]   = side[k].g[a][31] ? (~side[k].g[a] + 32'd1) : side[k].g[a];
          end
        end
      end else if (k == ST_SH) begin : g_norm
        always_comb begin
          side_fwd[k] = side[k];
          for (int a = 0; a < 3; a++) begin
            side_fwd[k].g[a] = side[k].g[a] << sh;
          end
        end
      end else if (k == ST_Q) begin : g_unit
        always_comb begin
          side_fwd[k] = side[k];
          for (int a = 0; a < 3; a++) begin
            side_fwd[k].u[a] = side[k].neg[a] ? -{1'b0, dv_q[a][aamr_pkg::DIV_STEPS]}
                                              : {1'b0, dv_q[a][aamr_pkg::DIV_STEPS]};
          end
        end
      end else begin : g_pass
        assign side_fwd[k] = side[k];
      end
    end
  endgenerate

  // Common left shift that brings the largest magnitude up to bit 30 or 31.
  always_comb begin
    mx = side[ST_MAG].g[0];
    if (side[ST_MAG].g[1] > mx) begin
      mx = side[ST_MAG].g[1];
    end
    if (side[ST_MAG].g[2] > mx) begin
      mx = side[ST_MAG].g[2];
    end
    msb = '0;
    for (int b = 0; b < 31; b++) begin
      if (mx[b]) begin
        msb = 5'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    sh <= (mx[31] || mx[30]) ? 5'd0 : 5'd30 - msb;
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      sq[a] <= side[ST_NORM].g[a] * side[ST_NORM].g[a];
    end
    nsum <= sq[0] + sq[1] + sq[2];
  end

  // Square root row.
  assign sq_rem[0]  = nsum;
  assign sq_root[0] = '0;

  genvar i, a;
  generate
    for (i = 0; i < aamr_pkg::SQRT_STEPS; i++) begin : g_sqrt
      aamr_sqrt_cell u_cell (
        .clk      (clk),
        .step     (5'(i)),
        .rem_in   (sq_rem[i]),
        .root_in  (sq_root[i]),
        .rem_out  (sq_rem[i+1]),
        .root_out (sq_root[i+1])
      );
    end

    // Divider rows: quotient of (g << 30) by the axis length.
    for (a = 0; a < 3; a++) begin : g_axis
      assign dv_len[a][0] = sq_root[aamr_pkg::SQRT_STEPS][31:0];
      assign dv_rem[a][0] = side[ST_LEN].g[a] >> 1;
      assign dv_q[a][0]   = '0;
      for (i = 0; i < aamr_pkg::DIV_STEPS; i++) begin : g_div
        aamr_div_cell u_cell (
          .clk     (clk),
          .len_in  (dv_len[a][i]),
          .rem_in  (dv_rem[a][i]),
          .nbit    ((i == 0) ? side[ST_LEN].g[a][0] : 1'b0),
          .q_in    (dv_q[a][i]),
          .len_out (dv_len[a][i+1]),
          .rem_out (dv_rem[a][i+1]),
          .q_out   (dv_q[a][i+1])
        );
      end
    end
  endgenerate

  // Quadrants two and three are folded by a half turn; the result is negated.
  assign flip_in = side[ST_Q].angle[15] ^ side[ST_Q].angle[14];
  assign phase   = {side[ST_Q].angle ^ {flip_in, 15'd0}, 16'd0};
  assign cx[0]   = aamr_pkg::CORDIC_X0;
  assign cy[0]   = '0;
  assign cz[0]   = CW'($signed(phase));

  generate
    for (i = 0; i < aamr_pkg::CORDIC_RUN; i++) begin : g_cordic
      aamr_cordic_cell u_cell (
        .clk   (clk),
        .step  (5'(i)),
        .x_in  (cx[i]),
        .y_in  (cy[i]),
        .z_in  (cz[i]),
        .x_out (cx[i+1]),
        .y_out (cy[i+1]),
        .z_out (cz[i+1])
      );
    end
  endgenerate

  assign flip_out = side[ST_CS].angle[15] ^ side[ST_CS].angle[14];

  // Rodrigues matrix and row product.
  always_ff @(posedge clk) begin
    logic signed [CW-1:0] cc;
    logic signed [65:0]   p;
    logic signed [65:0]   acc;
    logic signed [35:0]   v;
    logic                 sat;

    cc = flip_out ? -cx[aamr_pkg::CORDIC_RUN] : cx[aamr_pkg::CORDIC_RUN];
    c1 <= cc;
    s1 <= flip_out ? -cy[aamr_pkg::CORDIC_RUN] : cy[aamr_pkg::CORDIC_RUN];
    t1 <= aamr_pkg::Q30_ONE - cc;

    c2 <= c1;
    s2 <= s1;
    for (int j = 0; j < 3; j++) begin
      p     = t1 * $signed(side[ST_CS+1].u[j]);
      tm[j] <= CW'(p >>> 30);
    end

    c3 <= c2;
    for (int j = 0; j < 3; j++) begin
      for (int n = 0; n < 3; n++) begin
        p        = tm[j] * $signed(side[ST_CS+2].u[n]);
        pt[j][n] <= CW'(p >>> 30);
      end
      p     = s2 * $signed(side[ST_CS+2].u[j]);
      ps[j] <= CW'(p >>> 30);
    end

    r[0][0] <= clamp_unit((CW+1)'(c3) + (CW+1)'(pt[0][0]));
    r[0][1] <= clamp_unit((CW+1)'(pt[0][1]) + (CW+1)'(ps[2]));
    r[0][2] <= clamp_unit((CW+1)'(pt[0][2]) - (CW+1)'(ps[1]));
    r[1][0] <= clamp_unit((CW+1)'(pt[1][0]) - (CW+1)'(ps[2]));
    r[1][1] <= clamp_unit((CW+1)'(c3) + (CW+1)'(pt[1][1]));
    r[1][2] <= clamp_unit((CW+1)'(pt[1][2]) + (CW+1)'(ps[0]));
    r[2][0] <= clamp_unit((CW+1)'(pt[2][0]) + (CW+1)'(ps[1]));
    r[2][1] <= clamp_unit((CW+1)'(pt[2][1]) - (CW+1)'(ps[0]));
    r[2][2] <= clamp_unit((CW+1)'(c3) + (CW+1)'(pt[2][2]));

    for (int j = 0; j < 3; j++) begin
      for (int n = 0; n < 3; n++) begin
        mr[j][n] <= $signed(side[ST_CS+4].m[n]) * r[j][n];
      end
    end

    sat = 1'b0;
    for (int j = 0; j < 3; j++) begin
      acc = 66'(mr[j][0]) + 66'(mr[j][1]) + 66'(mr[j][2]) + 66'sd536870912;
      v   = 36'(acc >>> 30);
      if (v > 36'sd2147483647) begin
        sat = 1'b1;
        v   = 36'sd2147483647;
      end else if (v < -36'sd2147483648) begin
        sat = 1'b1;
        v   = -36'sd2147483648;
      end
      if (side[ST_CS+5].zero) begin
        v = 36'($signed(side[ST_CS+5].m[j]));
      end
      unique case (j)
        0:       out_c0 <= v[31:0];
        1:       out_c1 <= v[31:0];
        default: out_c2 <= v[31:0];
      endcase
    end
    out_c3    <= side[ST_CS+5].m[3];
    zero_axis <= side[ST_CS+5].zero;
    saturated <= sat && !side[ST_CS+5].zero;
  end

  assign done = vld[NST];

endmodule

/* rtl/aamr_sqrt_cell.sv */
// One step of the bit-pair integer square root row.
`timescale 1ns / 1ps

module aamr_sqrt_cell (
  input  logic                clk,
  input  aamr_pkg::step_t     step,
  input  logic [63:0]         rem_in,
  input  logic [63:0]         root_in,
  output logic [63:0]         rem_out,
  output logic [63:0]         root_out
);

  logic [63:0] bitv;
  logic [63:0] trial;

  assign bitv  = 64'd1 << (6'd62 - {step, 1'b0});
  assign trial = root_in + bitv;

  always_ff @(posedge clk) begin
    if (rem_in >= trial) begin
      rem_out  <= rem_in - trial;
      root_out <= (root_in >> 1) + bitv;
    end else begin
      rem_out  <= rem_in;
      root_out <= root_in >> 1;
    end
  end

endmodule

/* rtl/aamr_div_cell.sv */
// One restoring step of the axis normalizing divider row.
`timescale 1ns / 1ps

module aamr_div_cell (
  input  logic        clk,
  input  logic [31:0] len_in,
  input  logic [31:0] rem_in,
  input  logic        nbit,
  input  logic [30:0] q_in,
  output logic [31:0] len_out,
  output logic [31:0] rem_out,
  output logic [30:0] q_out
);

  logic [32:0] trial;
  logic [32:0] diff;
  logic        take;

  assign trial = {rem_in, nbit};
  assign diff  = trial - {1'b0, len_in};
  assign take  = trial >= {1'b0, len_in};

  always_ff @(posedge clk) begin
    len_out <= len_in;
    rem_out <= take ? diff[31:0] : trial[31:0];
    q_out   <= {q_in[29:0], take};
  end

endmodule

/* rtl/aamr_cordic_cell.sv */
// One rotation step of the sine and cosine CORDIC row.
`timescale 1ns / 1ps

module aamr_cordic_cell (
  input  logic                             clk,
  input  aamr_pkg::step_t                  step,
  input  logic signed [aamr_pkg::CW-1:0]   x_in,
  input  logic signed [aamr_pkg::CW-1:0]   y_in,
  input  logic signed [aamr_pkg::CW-1:0]   z_in,
  output logic signed [aamr_pkg::CW-1:0]   x_out,
  output logic signed [aamr_pkg::CW-1:0]   y_out,
  output logic signed [aamr_pkg::CW-1:0]   z_out
);

  logic signed [aamr_pkg::CW-1:0] dx;
  logic signed [aamr_pkg::CW-1:0] dy;
  logic signed [aamr_pkg::CW-1:0] ang;

  assign dx  = y_in >>> step;
  assign dy  = x_in >>> step;
  assign ang = $signed({2'b00, aamr_pkg::ATAN_TURNS[step]});

  always_ff @(posedge clk) begin
    if (!z_in[aamr_pkg::CW-1]) begin
      x_out <= x_in - dx;
      y_out <= y_in + dy;
      z_out <= z_in - ang;
    end else begin
      x_out <= x_in + dx;
      y_out <= y_in - dy;
      z_out <= z_in + ang;
    end
  end

endmodule
